@@ rtl/core/shc_pkg.sv @@
// Shared types, constants and helpers for the SECDED (16,11) codec.
// Used by shc_syndrome and secded_hamming_16_11_codec; no dependencies.
package shc_pkg;

   // Request kinds carried in req_tuser.
   localparam logic KIND_ENCODE = 1'b0;
   localparam logic KIND_DECODE = 1'b1;

   // Syndrome masks: each covers the positions whose index has that bit set.
   localparam logic [15:0] MASK_SYN_8 = 16'hFF00;
   localparam logic [15:0] MASK_SYN_4 = 16'hF0F0;
   localparam logic [15:0] MASK_SYN_2 = 16'hCCCC;
   localparam logic [15:0] MASK_SYN_1 = 16'hAAAA;

   // Decode status codes.
   typedef enum logic [1:0] {
      ST_NO_ERROR  = 2'd0,
      ST_CORRECTED = 2'd1,
      ST_DOUBLE    = 2'd2
   } status_type;

   // Syndrome and overall parity of one 16-bit word.
   typedef struct packed {
      logic [3:0] syn;
      logic       odd;
   } syn_type;

   // Place eleven data bits at the non-power-of-two positions, check bits zero.
   function automatic logic [15:0] place_data(input logic [10:0] d);
      logic [15:0] w;
      w        = '0;
      w[3]     = d[0];
      w[7:5]   = d[3:1];
      w[15:9]  = d[10:4];
      return w;
   endfunction

   // Pull the eleven data bits back out of a code word.
   function automatic logic [10:0] extract_data(input logic [15:0] w);
      return {w[15:9], w[7:5], w[3]};
   endfunction

endpackage

@@ rtl/core/shc_syndrome.sv @@
// Syndrome and overall parity generator for a 16-bit extended Hamming word.
// Depends on shc_pkg for the syndrome masks and syn_type.
module shc_syndrome import shc_pkg::*; (
   input  logic [15:0] word,
   output syn_type     result
);

   // Each syndrome bit is the parity over one group of positions.
   always_comb begin
      result.syn[3] = ^(word & MASK_SYN_8);
      result.syn[2] = ^(word & MASK_SYN_4);
      result.syn[1] = ^(word & MASK_SYN_2);
      result.syn[0] = ^(word & MASK_SYN_1);
      result.odd    = ^word;
   end

endmodule

@@ rtl/core/secded_hamming_16_11_codec.sv @@
// Extended Hamming (16,11) SECDED encoder and decoder, three register stages.
// A request passes through stage 1, stage 2 and stage 3 in order; the result is driven from the stage 3 registers.
// Throughput: one request per cycle; every stage holds under back-pressure.
// Reset: synchronous, active high; clears the stage valid bits only.
// Depends on shc_pkg and shc_syndrome.
module secded_hamming_16_11_codec import shc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,  // [10:0] data_in, [26:11] received_word, rest zero
   input  logic        req_tuser,  // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata   // [15:0] code_word, [26:16] data_out, [28:27] status
);

   // Stage valid bits and payload registers.
   logic        v1_ff, v2_ff, v3_ff;
   logic        v1_in, v2_in, v3_in;
   logic        kind1_ff, kind2_ff, kind3_ff;
   logic [15:0] word1_ff, word2_ff, word3_ff;
   logic [15:0] word1_in, word3_in;
   syn_type     syn2_ff, syn2_in;
   status_type  st3_ff, st3_in;
   logic        adv1, adv2, adv3;

   // A stage moves when it is empty or the stage after it moves.
   assign adv3       = !v3_ff || rsp_tready;
   assign adv2       = !v2_ff || adv3;
   assign adv1       = !v1_ff || adv2;
   assign req_tready = adv1;

   assign v1_in = adv1 ? req_tvalid : v1_ff;
   assign v2_in = adv2 ? v1_ff : v2_ff;
   assign v3_in = adv3 ? v2_ff : v3_ff;

   // Stage 1: an encode places its data bits; a decode takes the word as is.
   assign word1_in = (req_tuser == KIND_ENCODE) ? place_data(req_tdata[10:0])
                                                : req_tdata[26:11];

   // Stage 2: syndrome and overall parity, shared by both kinds.
   shc_syndrome u_syndrome (
      .word   (word1_ff),
      .result (syn2_in)
   );

   // Stage 3: insert check bits, or correct the word and grade the error.
   always_comb begin
      word3_in = word2_ff;
      st3_in   = ST_NO_ERROR;
      if (kind2_ff == KIND_ENCODE) begin
         // The syndrome of the placed word is exactly the set of check bits.
         word3_in[8] = syn2_ff.syn[3];
         word3_in[4] = syn2_ff.syn[2];
         word3_in[2] = syn2_ff.syn[1];
         word3_in[1] = syn2_ff.syn[0];
         word3_in[0] = syn2_ff.odd ^ (^syn2_ff.syn);
      end else if (syn2_ff.odd) begin
         // Odd parity: single error at the syndrome position, bit 0 included.
         word3_in = word2_ff ^ (16'd1 << syn2_ff.syn);
         st3_in   = ST_CORRECTED;
      end else if (syn2_ff.syn != 4'd0) begin
         st3_in = ST_DOUBLE;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
      end
   end

   // Payload registers, loaded when their stage moves.
   always_ff @(posedge clock) begin
      if (adv1) begin
         kind1_ff <= req_tuser;
         word1_ff <= word1_in;
      end
      if (adv2) begin
         kind2_ff <= kind1_ff;
         word2_ff <= word1_ff;
         syn2_ff  <= syn2_in;
      end
      if (adv3) begin
         kind3_ff <= kind2_ff;
         word3_ff <= word3_in;
         st3_ff   <= st3_in;
      end
   end

   // Result fields: unused fields of each kind read as zero.
   always_comb begin
      rsp_tvalid = v3_ff;
      rsp_tdata  = '0;
      if (kind3_ff == KIND_ENCODE) begin
         rsp_tdata[15:0] = word3_ff;
      end else begin
         rsp_tdata[26:16] = extract_data(word3_ff);
         rsp_tdata[28:27] = st3_ff;
      end
   end

`ifndef SYNTHESIS
   // An accepted request always occupies the first stage on the next edge.
   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> v1_ff)
      else $error("accepted request did not enter stage 1");

   // A full pipeline with a stalled output must refuse new requests.
   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      v1_ff && v2_ff && v3_ff && !rsp_tready |-> !req_tready)
      else $error("full pipeline accepted a request");

   // Every encoded word has even overall parity.
   a_even_code: assert property (@(posedge clock) disable iff (reset)
      v3_ff && kind3_ff == KIND_ENCODE |-> (^word3_ff) == 1'b0)
      else $error("encoded word has odd parity");

   // A valid result never carries the unused status code, and the padding stays zero.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[28:27] != 2'd3 && rsp_tdata[31:29] == 3'd0)
      else $error("result status out of range");

   // A decode flagged as corrected came from a word with odd parity.
   a_corrected_odd: assert property (@(posedge clock) disable iff (reset)
      v2_ff && adv3 && kind2_ff == KIND_DECODE && !syn2_ff.odd |=> st3_ff != ST_CORRECTED)
      else $error("even-parity word marked as corrected");
`endif

endmodule

@@ tb/tb_secded_hamming_16_11_codec.sv @@
// Self-checking testbench for the SECDED (16,11) codec: directed and random
// encode/decode requests with error injection, checked by an in-bench predictor.
// Depends on shc_pkg and the secded_hamming_16_11_codec RTL.
`timescale 1ns / 100ps

module tb_secded_hamming_16_11_codec;
   import shc_pkg::*;

   // Holds the predicted results of accepted requests and checks each result in order.
   class codec_scoreboard;

      typedef struct packed {
         logic [15:0]          code_word;
         logic [10:0]          data_out;
         shc_pkg::status_type  status;
      } codec_result_type;

      codec_result_type awaited_results[$];
      int               failures;

      function new();
         failures = 0;
      endfunction

      // Build a valid code word: data at the non-power-of-two positions, then the
      // four check bits, then bit 0 for even parity over the whole word.
      static function logic [15:0] encode_data(input logic [10:0] d);
         logic [15:0] w;
         w    = {d[10:4], 1'b0, d[3:1], 1'b0, d[0], 3'b000};
         w[8] = ^(w & shc_pkg::MASK_SYN_8);
         w[4] = ^(w & shc_pkg::MASK_SYN_4);
         w[2] = ^(w & shc_pkg::MASK_SYN_2);
         w[1] = ^(w & shc_pkg::MASK_SYN_1);
         w[0] = ^w[15:1];
         return w;
      endfunction

      // Work out the codec's answer to one request.
      static function codec_result_type compute_result(input logic kind,
                                                       input logic [10:0] data_in,
                                                       input logic [15:0] word);
         codec_result_type r;
         logic [15:0]      fixed;
         logic [3:0]       syn;
         logic             odd;
         r = '0;
         if (kind == shc_pkg::KIND_ENCODE) begin
            r.code_word = encode_data(data_in);
            r.status    = shc_pkg::ST_NO_ERROR;
         end else begin
            fixed = word;
            odd   = ^word;
            syn   = {^(word & shc_pkg::MASK_SYN_8), ^(word & shc_pkg::MASK_SYN_4),
                     ^(word & shc_pkg::MASK_SYN_2), ^(word & shc_pkg::MASK_SYN_1)};
            // Odd parity means one flipped bit at the syndrome position (bit 0 if zero).
            if (odd) begin
               fixed[syn] = ~fixed[syn];
               r.status   = shc_pkg::ST_CORRECTED;
            end else if (syn != 4'd0) begin
               r.status = shc_pkg::ST_DOUBLE;
            end else begin
               r.status = shc_pkg::ST_NO_ERROR;
            end
            r.data_out = {fixed[15:9], fixed[7:5], fixed[3]};
         end
         return r;
      endfunction

      function void note_request(input logic kind, input logic [10:0] data_in,
                                 input logic [15:0] word);
         awaited_results.push_back(compute_result(kind, data_in, word));
      endfunction

      function void check_result(input logic [31:0] tdata);
         codec_result_type want;
         if (awaited_results.size() == 0) begin
            $error("result %0h arrived with no request outstanding", tdata);
            failures++;
            return;
         end
         want = awaited_results.pop_front();
         if (tdata[15:0] !== want.code_word) begin
            $error("code_word: expected %0h, got %0h", want.code_word, tdata[15:0]);
            failures++;
         end
         if (tdata[26:16] !== want.data_out) begin
            $error("data_out: expected %0h, got %0h", want.data_out, tdata[26:16]);
            failures++;
         end
         if (tdata[28:27] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, tdata[28:27]);
            failures++;
         end
      endfunction

   endclass

   localparam int RANDOM_REQUESTS = 1400;
   localparam int HOLD_START      = 600;
   localparam int LONG_HOLD       = 80;
   localparam int DRAIN_CYCLES    = 12;
   localparam int CYCLE_LIMIT     = 200000;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        req_tuser  = KIND_ENCODE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   codec_scoreboard board;
   int              cycle_count = 0;

   always #5 clock = ~clock;

   secded_hamming_16_11_codec i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Watch both channels: predict on each accepted request, check each result.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            board.note_request(req_tuser, req_tdata[10:0], req_tdata[26:11]);
         end
         if (rsp_tvalid && rsp_tready) begin
            board.check_result(rsp_tdata);
         end
      end
   end

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_secded_hamming_16_11_codec: FAIL");
         $finish;
      end
   end

   // Offer one request and hold it until the block takes it.
   task automatic offer(input logic kind, input logic [10:0] data_in, input logic [15:0] word);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {5'b00000, word, data_in};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic rest_sender(input int cycles);
      req_tvalid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Encode requests, well-formed code words with zero to three flipped bits, and raw noise.
   task automatic send_random_request();
      int          pick;
      int          flips;
      int          pos;
      logic [10:0] d;
      logic [15:0] w;
      d    = 11'($urandom_range(0, 2047));
      w    = 16'($urandom_range(0, 65535));
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
         offer(KIND_ENCODE, d, w);
      end else if (pick < 85) begin
         w     = board.encode_data(11'($urandom_range(0, 2047)));
         pick  = $urandom_range(0, 99);
         flips = (pick < 25) ? 0 : (pick < 65) ? 1 : (pick < 90) ? 2 : 3;
         pos   = $urandom_range(0, 15);
         if (flips >= 1) w[pos] = ~w[pos];
         // The second flip always lands on a different bit, so it stays a double error.
         if (flips >= 2) begin
            pos    = (pos + 1 + $urandom_range(0, 14)) % 16;
            w[pos] = ~w[pos];
         end
         if (flips >= 3) begin
            pos    = $urandom_range(0, 15);
            w[pos] = ~w[pos];
         end
         offer(KIND_DECODE, d, w);
      end else begin
         offer(KIND_DECODE, d, w);
      end
   endtask

   // Result side: its own stall pattern, with one long hold-off so the pipe fills.
   initial begin
      int  seen;
      int  run;
      int  pick;
      bit  held;
      seen = 0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         pick = $urandom_range(0, 9);
         if (!held && seen >= HOLD_START) begin
            rsp_tready <= 1'b0;
            run         = LONG_HOLD;
            held        = 1'b1;
         end else if (pick < 2) begin
            rsp_tready <= 1'b1;
            run         = $urandom_range(20, 60);
         end else if (pick < 7) begin
            rsp_tready <= 1'b1;
            run         = $urandom_range(1, 5);
         end else begin
            rsp_tready <= 1'b0;
            run         = $urandom_range(1, 6);
         end
         repeat (run) @(posedge clock);
         seen += run;
      end
   end

   // Request side: reset, directed cases, then random bursts.
   initial begin
      int          burst;
      int          gap;
      logic [15:0] good;
      board = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Encode at the data extremes and alternating patterns.
      offer(KIND_ENCODE, 11'h000, 16'hFFFF);
      offer(KIND_ENCODE, 11'h7FF, 16'h0000);
      offer(KIND_ENCODE, 11'h555, 16'hAAAA);
      offer(KIND_ENCODE, 11'h2AA, 16'h5555);
      offer(KIND_ENCODE, 11'h001, 16'h0000);
      offer(KIND_ENCODE, 11'h400, 16'h0000);

      // Decode: clean word, then single errors in the overall bit, check bits and data.
      good = board.encode_data(11'h5A3);
      offer(KIND_DECODE, 11'h7FF, good);
      offer(KIND_DECODE, 11'h000, good ^ 16'h0001);
      offer(KIND_DECODE, 11'h000, good ^ 16'h0002);
      offer(KIND_DECODE, 11'h000, good ^ 16'h0100);
      offer(KIND_DECODE, 11'h000, good ^ 16'h8000);
      offer(KIND_DECODE, 11'h000, good ^ 16'h0008);
      // Double errors, one of them including the overall parity bit.
      offer(KIND_DECODE, 11'h000, good ^ 16'h0006);
      offer(KIND_DECODE, 11'h000, good ^ 16'h0201);
      // Three flipped bits are miscorrected as a single error.
      offer(KIND_DECODE, 11'h000, good ^ 16'h2410);
      // Word extremes: all zeros and all ones are valid, a lone bit 0 is not.
      offer(KIND_DECODE, 11'h000, 16'h0000);
      offer(KIND_DECODE, 11'h7FF, 16'hFFFF);
      offer(KIND_DECODE, 11'h000, 16'h0001);
      offer(KIND_DECODE, 11'h000, 16'hFFFE);
      offer(KIND_DECODE, 11'h000, 16'h8001);

      // Random part in bursts, some back to back and some with idle gaps.
      burst = 0;
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (burst == 0) begin
            burst = $urandom_range(1, 48);
            gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) rest_sender(gap);
         end
         send_random_request();
         burst--;
      end
      req_tvalid <= 1'b0;

      // Let the last request be noted, wait for every result, then watch for strays.
      @(posedge clock);
      while (board.awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.failures == 0 && board.awaited_results.size() == 0) begin
         $display("tb_secded_hamming_16_11_codec: PASS");
      end else begin
         $display("tb_secded_hamming_16_11_codec: FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/shc_pkg.sv
rtl/core/shc_syndrome.sv
rtl/core/secded_hamming_16_11_codec.sv
tb/tb_secded_hamming_16_11_codec.sv
